### sv/fps_pkg.sv
`default_nettype none

package fps_pkg;

  localparam int unsigned NUM_PAT    = 23;
  localparam int unsigned MAX_LEN    = 18;
  localparam int unsigned HIST_DEPTH = MAX_LEN - 1;
  localparam int unsigned IDX_W      = 5;

  typedef logic [7:0]               byte_t;
  typedef logic [NUM_PAT-1:0]       hit_vec_t;
  typedef logic [IDX_W-1:0]         pat_idx_t;
  typedef logic [8*MAX_LEN-1:0]     sig_t;
  // element 0 is the byte being scanned, element k the k-th older byte
  typedef logic [MAX_LEN-1:0][7:0]  window_t;
  typedef logic [HIST_DEPTH-1:0][7:0] hist_t;

  // Strings are right-justified: byte 0 holds the last character.
  localparam sig_t SIG_TABLE [NUM_PAT] = '{
    sig_t'("os.delete"),       sig_t'("os.remove"),      sig_t'("rm -rf"),
    sig_t'("system("),         sig_t'("subprocess"),     sig_t'("powershell"),
    sig_t'("invoke-webrequest"), sig_t'("wget "),        sig_t'("curl "),
    sig_t'("del "),            sig_t'("deletefile"),     sig_t'("removedirectory"),
    sig_t'("format c:"),       sig_t'("shutdown -s"),    sig_t'("shutdown /s"),
    sig_t'("rmdir /s /q"),     sig_t'("drop table"),     sig_t'("eval("),
    sig_t'("exec("),           sig_t'("shell.exec"),     sig_t'("malloc("),
    sig_t'("virtualallocex"),  sig_t'("createremotethread")
  };

  function automatic int unsigned sig_len(int unsigned p);
    int unsigned n;
    n = 0;
    for (int unsigned k = 0; k < MAX_LEN; k++) begin
      if (SIG_TABLE[p][8*k +: 8] != 8'h00) begin
        n = k + 1;
      end
    end
    return n;
  endfunction

  function automatic byte_t fold_case(byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/fps_ifs.sv
`default_nettype none

interface fps_in_if;
  logic           valid;
  logic           ready;
  fps_pkg::byte_t data_byte;
  logic           byte_present;
  logic           last;

  modport source(output valid, data_byte, byte_present, last, input ready);
  modport sink(input valid, data_byte, byte_present, last, output ready);
endinterface

interface fps_out_if;
  logic              valid;
  logic              ready;
  logic              found;
  fps_pkg::pat_idx_t pattern_index;

  modport source(output valid, found, pattern_index, input ready);
  modport sink(input valid, found, pattern_index, output ready);
endinterface

`default_nettype wire

### sv/fps_matcher.sv
`default_nettype none

// One comparator row per signature against the byte window.
module fps_matcher (
  input  var fps_pkg::window_t  win_i,
  output var fps_pkg::hit_vec_t match_o
);

  for (genvar p = 0; p < fps_pkg::NUM_PAT; p++) begin : g_pat
    localparam int unsigned Len = fps_pkg::sig_len(p);
    logic [fps_pkg::MAX_LEN-1:0] eq;

    for (genvar k = 0; k < fps_pkg::MAX_LEN; k++) begin : g_chr
      // positions beyond the signature length are don't-care
      assign eq[k] = (k >= Len) ||
                     (win_i[k] == fps_pkg::SIG_TABLE[p][8*k +: 8]);
    end

    assign match_o[p] = (Len != 0) && (&eq);
  end

endmodule

`default_nettype wire

### sv/forbidden_pattern_scanner.sv
// forbidden_pattern_scanner
//
// Scans file content one byte per request for 23 built-in ASCII
// signatures, ignoring letter case. Input channel in_i carries data_byte,
// byte_present and last; a request with last set closes the file and
// produces exactly one verdict on out_o (found, pattern_index = lowest
// signature index that occurred, 0 when none). Requests without last
// produce nothing.
//
// Throughput: one request per cycle unless a last request waits behind a
// stalled verdict; the combinational comparator array against the 17-byte
// history sets the rate. Verdicts pass the input stage and output register.
//
// Reset (rst_ni low, async) empties both stages and clears history and hit
// flags. When the receiver stalls, the verdict waits in the output register
// and scanning continues; a second last request waits in the input stage,
// and only then does in_i.ready drop.

`default_nettype none

module forbidden_pattern_scanner (
  input  var logic  clk_i,
  input  var logic  rst_ni,
  fps_in_if.sink    in_i,
  fps_out_if.source out_o
);

  // input stage
  logic           s1_valid_q;
  fps_pkg::byte_t s1_data_q;
  logic           s1_present_q;
  logic           s1_last_q;
  logic           s1_go;

  // scan state
  fps_pkg::hist_t    hist_q, hist_d;
  fps_pkg::hit_vec_t hits_q, hits_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic              found_q;
  fps_pkg::pat_idx_t idx_q;

  fps_pkg::byte_t    cur_byte;
  fps_pkg::window_t  window;
  fps_pkg::hit_vec_t match_vec;
  fps_pkg::hit_vec_t hits_new;
  fps_pkg::pat_idx_t first_idx;

  // A non-last request always moves on; a last one needs a free result slot.
  assign s1_go      = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_data_q    <= in_i.data_byte;
      s1_present_q <= in_i.byte_present;
      s1_last_q    <= in_i.last;
    end
  end

  assign cur_byte = fps_pkg::fold_case(s1_data_q);
  assign window   = {hist_q, cur_byte};

  fps_matcher u_matcher (
    .win_i   (window),
    .match_o (match_vec)
  );

  // absent bytes neither match nor shift the history
  assign hits_new = s1_present_q ? (hits_q | match_vec) : hits_q;

  always_comb begin
    first_idx = '0;
    for (int i = fps_pkg::NUM_PAT - 1; i >= 0; i--) begin
      if (hits_new[i]) begin
        first_idx = fps_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    hist_d = hist_q;
    hits_d = hits_q;
    if (s1_go) begin
      if (s1_last_q) begin
        // verdict closes the file: nothing spans into the next one
        hist_d = '0;
        hits_d = '0;
      end else if (s1_present_q) begin
        hist_d = {hist_q[fps_pkg::HIST_DEPTH-2:0], cur_byte};
        hits_d = hits_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      hits_q <= '0;
    end else begin
      hist_q <= hist_d;
      hits_q <= hits_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (s1_go && s1_last_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      found_q <= |hits_new;
      idx_q   <= first_idx;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.found         = found_q;
  assign out_o.pattern_index = idx_q;

endmodule

`default_nettype wire

### sv/fps_checker.sv
`default_nettype none

module fps_checker (
  input var logic              clk_i,
  input var logic              rst_ni,
  input var logic              in_valid_i,
  input var logic              in_ready_i,
  input var logic              in_last_i,
  input var logic              out_valid_i,
  input var logic              out_ready_i,
  input var logic              out_found_i,
  input var fps_pkg::pat_idx_t out_pattern_index_i
);

  logic last_acc;
  assign last_acc = in_valid_i && in_ready_i && in_last_i;

  // stalled verdict holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_found_i) && $stable(out_pattern_index_i))
    else $error("verdict changed while stalled");

  // no hit means index zero; a hit names a real signature
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (out_found_i ? (out_pattern_index_i < fps_pkg::pat_idx_t'(fps_pkg::NUM_PAT))
                   : (out_pattern_index_i == '0)))
    else $error("pattern_index inconsistent with found");

  // a verdict appearing from idle comes from a last request that went through the input stage
  a_verdict_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(last_acc, 2))
    else $error("verdict without a closing request");

  // input only backs up behind a stalled verdict
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule

bind forbidden_pattern_scanner fps_checker u_fps_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .in_last_i           (in_i.last),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_found_i         (out_o.found),
  .out_pattern_index_i (out_o.pattern_index)
);

`default_nettype wire
